// ----- src/rmt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmt_pkg
// Types, codes and helpers shared by the refcount membership table modules.
// ----------------------------------------------------------------------------
package rmt_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int ID_W        = 6;
    localparam int CNT_W       = 15;
    localparam int DELTA_W     = 16;
    localparam int CFG_W       = 7;
    localparam int OP_W        = 4;

    localparam logic [CFG_W-1:0] BOUND_MAX = CFG_W'(MAX_ENTRIES);
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD_ENABLE = 4'd0;
    localparam logic [OP_W-1:0] OP_ADD_REMOVE = 4'd1;
    localparam logic [OP_W-1:0] OP_HELD       = 4'd2;
    localparam logic [OP_W-1:0] OP_EXCLUDED   = 4'd3;
    localparam logic [OP_W-1:0] OP_GATE       = 4'd4;
    localparam logic [OP_W-1:0] OP_QUEUED     = 4'd5;
    localparam logic [OP_W-1:0] OP_QUERY      = 4'd6;
    localparam logic [OP_W-1:0] OP_LIST_OFFER = 4'd7;
    localparam logic [OP_W-1:0] OP_LIST_TREE  = 4'd8;
    localparam logic [OP_W-1:0] OP_CLEAR      = 4'd9;

    // entry state codes
    localparam logic [1:0] ST_HIDDEN = 2'd0;
    localparam logic [1:0] ST_GREYED = 2'd1;
    localparam logic [1:0] ST_LISTED = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic [ID_W-1:0]           entry_id;
        logic signed [DELTA_W-1:0] delta;
        logic                      flag_value;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0]  result_id;
        logic             found;
        logic [1:0]       entry_state;
        logic [CNT_W-1:0] enable_total;
        logic [CNT_W-1:0] remove_total;
        logic             held_bit;
        logic             excluded_bit;
        logic             gate_bit;
        logic             queued_bit;
        logic             id_in_range;
        logic             count_error;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic [CNT_W-1:0] enable_cnt;
        logic [CNT_W-1:0] remove_cnt;
        logic             held;
        logic             excluded;
        logic             gate;
        logic             queued;
    } t_entry;

    // state follows from counts and flags; queued plays no part
    function automatic logic [1:0] f_entry_state(input t_entry e);
        logic member;
        member = (e.enable_cnt != '0) && (e.remove_cnt == '0) && !e.held && !e.excluded;
        if (!member) begin
            return ST_HIDDEN;
        end
        return e.gate ? ST_GREYED : ST_LISTED;
    endfunction

    function automatic t_out_item f_describe(input logic [ID_W-1:0] id, input t_entry e,
                                             input logic err, input logic last);
        t_out_item o;
        o.result_id    = id;
        o.found        = 1'b1;
        o.entry_state  = f_entry_state(e);
        o.enable_total = e.enable_cnt;
        o.remove_total = e.remove_cnt;
        o.held_bit     = e.held;
        o.excluded_bit = e.excluded;
        o.gate_bit     = e.gate;
        o.queued_bit   = e.queued;
        o.id_in_range  = 1'b1;
        o.count_error  = err;
        o.last         = last;
        return o;
    endfunction

endpackage

// ----- src/rmt_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmt_store
// Entry memory with one write and one registered read port. Per-entry valid
// bits make unwritten or cleared entries read as zero.
// ----------------------------------------------------------------------------
module rmt_store (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clear,
    input  logic                 i_we,
    input  logic [rmt_pkg::ID_W-1:0] i_waddr,
    input  rmt_pkg::t_entry      i_wdata,
    input  logic [rmt_pkg::ID_W-1:0] i_raddr,
    output rmt_pkg::t_entry      o_rdata
);
    import rmt_pkg::*;

    t_entry                 r_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] r_valid;
    t_entry                 r_rd;
    logic                   r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= r_valid[i_raddr];
            if (i_clear) begin
                r_valid <= '0;
            end else if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
        end
    end

    assign o_rdata = r_rd_valid ? r_rd : '0;

endmodule

// ----- src/rmt_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmt_unit
// Shared entry unit: saturating refcount add, flag update and scan match.
// ----------------------------------------------------------------------------
module rmt_unit (
    input  logic [rmt_pkg::OP_W-1:0]           i_op,
    input  rmt_pkg::t_entry                    i_entry,
    input  logic signed [rmt_pkg::DELTA_W-1:0] i_delta,
    input  logic                               i_flag,
    output rmt_pkg::t_entry                    o_entry,
    output logic                               o_err,
    output logic                               o_hit
);
    import rmt_pkg::*;

    logic [CNT_W-1:0]      w_cur;
    logic signed [CNT_W+1:0] w_sum;
    logic [CNT_W-1:0]      w_sat;
    logic                  w_sat_err;
    logic [1:0]            w_state;

    // one adder serves both counts
    assign w_cur = (i_op == OP_ADD_REMOVE) ? i_entry.remove_cnt : i_entry.enable_cnt;
    assign w_sum = $signed({2'b00, w_cur}) + $signed({i_delta[DELTA_W-1], i_delta});

    always_comb begin
        if (w_sum[CNT_W+1]) begin
            w_sat     = '0;
            w_sat_err = 1'b1;
        end else if (w_sum[CNT_W]) begin
            w_sat     = COUNT_MAX;
            w_sat_err = 1'b1;
        end else begin
            w_sat     = w_sum[CNT_W-1:0];
            w_sat_err = 1'b0;
        end
    end

    assign w_state = f_entry_state(i_entry);

    always_comb begin
        o_entry = i_entry;
        o_err   = 1'b0;
        o_hit   = 1'b0;
        unique case (i_op)
            OP_ADD_ENABLE: begin
                o_entry.enable_cnt = w_sat;
                o_err              = w_sat_err;
            end
            OP_ADD_REMOVE: begin
                o_entry.remove_cnt = w_sat;
                o_err              = w_sat_err;
            end
            OP_HELD:       o_entry.held     = i_flag;
            OP_EXCLUDED:   o_entry.excluded = i_flag;
            OP_GATE:       o_entry.gate     = i_flag;
            OP_QUEUED:     o_entry.queued   = i_flag;
            OP_LIST_OFFER: o_hit = (w_state == ST_LISTED) && !i_entry.queued;
            OP_LIST_TREE:  o_hit = (w_state != ST_HIDDEN);
            default: begin
            end
        endcase
    end

endmodule

// ----- src/refcount_membership_table_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcount_membership_table_top
// Table of refcounted entries with flags, updated, queried and scanned by
// a small sequencer around one shared entry unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one operation per
//   transaction; output channel (o_out_valid / i_out_stall) carries results,
//   the final one of each operation marked by last (codes above OP_CLEAR are
//   taken but give no result). The bound register is written over
//   i_cfg_valid / o_cfg_ready, which is always ready. An update or query
//   reads its entry from the entry memory, modifies it and writes it back
//   in the execute state, which registers its result; the next operation
//   can be taken in the cycle the result leaves, and none is taken before.
//   Clear and out-of-range ids answer straight from the idle state. A scan
//   walks the entries through the memory read port, one entry per cycle
//   while the receiver keeps up. One match is held back so the final
//   one can carry last.
//   Reset clears the bound to zero and marks every entry empty at once.
//   When the receiver stalls, the result register holds and the scan halts
//   on the next match until the register frees up.
// ----------------------------------------------------------------------------
module refcount_membership_table_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  rmt_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output rmt_pkg::t_out_item            o_out_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rmt_pkg::CFG_W-1:0]     i_cfg_data
);
    import rmt_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0]                r_state, n_state;
    logic [CFG_W-1:0]          r_entries_in_use;
    logic [OP_W-1:0]           r_op;
    logic [ID_W-1:0]           r_id;
    logic signed [DELTA_W-1:0] r_delta;
    logic                      r_flag;
    logic [ID_W-1:0]           r_idx, n_idx;
    t_out_item                 r_pend, n_pend;
    logic                      r_pend_valid, n_pend_valid;
    t_out_item                 r_out;
    logic                      r_out_valid;

    logic [CFG_W-1:0] w_bound;
    logic             w_out_free;
    logic             w_accept;
    logic             w_load;
    t_out_item        w_load_item;
    logic             w_mem_clear;
    logic             w_mem_we;
    logic [ID_W-1:0]  w_rd_addr;
    t_entry           w_rd_entry;
    t_entry           w_new_entry;
    logic             w_err;
    logic             w_hit;
    logic             w_end;

    assign w_bound     = (r_entries_in_use > BOUND_MAX) ? BOUND_MAX : r_entries_in_use;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == S_IDLE) && w_out_free);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign w_end       = ({1'b0, r_idx} + CFG_W'(1)) == w_bound;

    rmt_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_mem_clear),
        .i_we    (w_mem_we),
        .i_waddr (r_id),
        .i_wdata (w_new_entry),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_entry)
    );

    rmt_unit u_unit (
        .i_op    (r_op),
        .i_entry (w_rd_entry),
        .i_delta (r_delta),
        .i_flag  (r_flag),
        .o_entry (w_new_entry),
        .o_err   (w_err),
        .o_hit   (w_hit)
    );

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        w_load       = 1'b0;
        w_load_item  = '0;
        w_mem_clear  = 1'b0;
        w_mem_we     = 1'b0;
        w_rd_addr    = r_idx;
        unique case (r_state)
            S_IDLE: begin
                w_rd_addr = i_in_item.entry_id;
                if (w_accept) begin
                    priority if (i_in_item.operation == OP_CLEAR) begin
                        w_mem_clear      = 1'b1;
                        w_load           = 1'b1;
                        w_load_item.last = 1'b1;
                    end else if (i_in_item.operation == OP_LIST_OFFER
                                 || i_in_item.operation == OP_LIST_TREE) begin
                        if (w_bound == '0) begin
                            w_load           = 1'b1;
                            w_load_item.last = 1'b1;
                        end else begin
                            w_rd_addr    = '0;
                            n_idx        = '0;
                            n_pend_valid = 1'b0;
                            n_state      = S_SCAN;
                        end
                    end else if (i_in_item.operation <= OP_QUERY) begin
                        if ({1'b0, i_in_item.entry_id} >= w_bound) begin
                            w_load                = 1'b1;
                            w_load_item.result_id = i_in_item.entry_id;
                            w_load_item.last      = 1'b1;
                        end else begin
                            n_state = S_EXEC;
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EXEC: begin
                // read-modify-write of one entry; a query writes back the same value
                w_mem_we    = 1'b1;
                w_load      = 1'b1;
                w_load_item = f_describe(r_id, w_new_entry, w_err, 1'b1);
                n_state     = S_IDLE;
            end
            S_SCAN: begin
                // a new match pushes the held one out, so wait if the output is busy
                if (!(w_hit && r_pend_valid && !w_out_free)) begin
                    if (w_hit) begin
                        if (r_pend_valid) begin
                            w_load      = 1'b1;
                            w_load_item = r_pend;
                        end
                        n_pend       = f_describe(r_idx, w_rd_entry, 1'b0, 1'b0);
                        n_pend_valid = 1'b1;
                    end
                    if (w_end) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_idx     = r_idx + ID_W'(1);
                        w_rd_addr = r_idx + ID_W'(1);
                    end
                end
            end
            S_FLUSH: begin
                if (w_out_free) begin
                    w_load = 1'b1;
                    if (r_pend_valid) begin
                        w_load_item = r_pend;
                    end
                    w_load_item.last = 1'b1;
                    n_pend_valid     = 1'b0;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_entries_in_use <= '0;
            r_idx            <= '0;
            r_pend_valid     <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_pend_valid <= n_pend_valid;
            if (i_cfg_valid) begin
                r_entries_in_use <= i_cfg_data;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (w_load) begin
            r_out <= w_load_item;
        end
        if (w_accept) begin
            r_op    <= i_in_item.operation;
            r_id    <= i_in_item.entry_id;
            r_delta <= i_in_item.delta;
            r_flag  <= i_in_item.flag_value;
        end
    end

endmodule
